[rtl/ses_pkg.sv]
// shared types and constants for the sorted sparse entry store
// no dependencies; used by every module of the block
package ses_pkg;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_GET  = 2'd0,
    OP_SET  = 2'd1,
    OP_ACC  = 2'd2,
    OP_DUMP = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_SAT   = 2'd3
  } status_e;

  // controller sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_SHUP,
    S_PUT,
    S_SHDN,
    S_DUMP
  } state_e;

  // configuration register indexes
  localparam logic CfgNumRows = 1'b0;
  localparam logic CfgNumCols = 1'b1;

  localparam int unsigned CapacityDefault = 64;
  localparam int unsigned DimWidth        = 11;
  localparam int unsigned CoordWidth      = 10;
  localparam int unsigned KeyWidth        = 2 * CoordWidth;
  localparam logic [DimWidth-1:0] MaxDim   = 11'd1024;
  localparam logic [DimWidth-1:0] DimReset = 11'd1024;

  // input transaction payload
  typedef struct packed {
    op_e                    op;
    logic [CoordWidth-1:0]  row_index;
    logic [CoordWidth-1:0]  col_index;
    logic signed [31:0]     operand_value;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic [CoordWidth-1:0]  out_row;
    logic [CoordWidth-1:0]  out_col;
    logic signed [31:0]     out_value;
    logic                   found;
    status_e                status;
    logic                   last;
  } out_item_t;

  // one stored entry: row-major key and value
  typedef struct packed {
    logic [KeyWidth-1:0]    key;
    logic signed [31:0]     value;
  } entry_t;

endpackage

[rtl/ses_entry_mem.sv]
// entry memory: one write port, one read port, registered read data
// depends on ses_pkg for the entry type
module ses_entry_mem #(
  parameter int unsigned Depth = ses_pkg::CapacityDefault,
  localparam int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  ses_pkg::entry_t      wdata_i,
  output ses_pkg::entry_t      rdata_o
);

  ses_pkg::entry_t mem_q [Depth];
  ses_pkg::entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ses_ctrl.sv]
// sequencer: key search, sorted insert and delete shifts, dump streaming
// depends on ses_pkg; drives the ports of ses_entry_mem
module ses_ctrl #(
  parameter int unsigned Capacity = ses_pkg::CapacityDefault,
  localparam int unsigned AddrWidth = $clog2(Capacity),
  localparam int unsigned CntWidth  = $clog2(Capacity + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  ses_pkg::in_item_t              in_item_i,
  input  logic [ses_pkg::DimWidth-1:0]   num_rows_i,
  input  logic [ses_pkg::DimWidth-1:0]   num_cols_i,
  output logic                           result_strobe_o,
  output ses_pkg::out_item_t             result_o,
  output logic                           mem_re_o,
  output logic [AddrWidth-1:0]           mem_raddr_o,
  output logic                           mem_we_o,
  output logic [AddrWidth-1:0]           mem_waddr_o,
  output ses_pkg::entry_t                mem_wdata_o,
  input  ses_pkg::entry_t                mem_rdata_i
);

  localparam logic [CntWidth-1:0] CapCnt = CntWidth'(Capacity);

  ses_pkg::state_e    state_q, state_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [AddrWidth-1:0] idx_q, idx_d;
  logic [CntWidth-1:0]  pos_q, pos_d;
  logic                 hit_q, hit_d;
  logic signed [31:0]   oldv_q, oldv_d;
  ses_pkg::in_item_t    req_q, req_d;
  ses_pkg::out_item_t   res_q, res_d;
  logic                 res_vld_q, res_vld_d;

  logic [ses_pkg::DimWidth-1:0] rlim_w, clim_w;
  logic                 in_range_w;
  logic [ses_pkg::KeyWidth-1:0] key_w;
  logic signed [32:0]   sum_w;
  logic                 ovf_w;
  logic signed [31:0]   satv_w;
  logic signed [31:0]   newv_w;
  ses_pkg::status_e     stat_w;
  logic                 is_acc_hit_w;
  logic                 rk_lt_w;
  logic                 scan_end_w;
  logic                 shift_dn_w;
  logic                 append_w;
  logic                 dump_last_w;

  // range check against the effective bounds
  always_comb begin
    rlim_w = (num_rows_i < ses_pkg::MaxDim) ? num_rows_i : ses_pkg::MaxDim;
    clim_w = (num_cols_i < ses_pkg::MaxDim) ? num_cols_i : ses_pkg::MaxDim;
    in_range_w = ({1'b0, in_item_i.row_index} < rlim_w) &&
                 ({1'b0, in_item_i.col_index} < clim_w);
  end

  // new value of the addressed entry, saturating accumulate
  assign key_w        = {req_q.row_index, req_q.col_index};
  assign sum_w        = {oldv_q[31], oldv_q} + {req_q.operand_value[31], req_q.operand_value};
  assign ovf_w        = sum_w[32] != sum_w[31];
  assign satv_w       = sum_w[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  assign is_acc_hit_w = (req_q.op == ses_pkg::OP_ACC) && hit_q;
  assign newv_w       = is_acc_hit_w ? (ovf_w ? satv_w : sum_w[31:0]) : req_q.operand_value;
  assign stat_w       = (is_acc_hit_w && ovf_w) ? ses_pkg::STAT_SAT : ses_pkg::STAT_OK;

  // loop conditions shared by next-state and output logic
  assign rk_lt_w     = mem_rdata_i.key < key_w;
  assign scan_end_w  = (CntWidth'(idx_q) + CntWidth'(1)) == cnt_q;
  assign shift_dn_w  = (pos_q + CntWidth'(1)) < cnt_q;
  assign append_w    = pos_q == cnt_q;
  assign dump_last_w = (CntWidth'(idx_q) + CntWidth'(1)) == cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ses_pkg::S_IDLE: begin
        if (start) begin
          if (in_item_i.op == ses_pkg::OP_DUMP) begin
            if (cnt_q != '0) state_d = ses_pkg::S_DUMP;
          end else if (in_range_w) begin
            state_d = (cnt_q == '0) ? ses_pkg::S_ACT : ses_pkg::S_SCAN;
          end
        end
      end
      ses_pkg::S_SCAN: begin
        if (!rk_lt_w || scan_end_w) state_d = ses_pkg::S_ACT;
      end
      ses_pkg::S_ACT: begin
        state_d = ses_pkg::S_IDLE;
        if (req_q.op != ses_pkg::OP_GET) begin
          if (newv_w == '0) begin
            if (hit_q && shift_dn_w) state_d = ses_pkg::S_SHDN;
          end else if (!hit_q && cnt_q != CapCnt && !append_w) begin
            state_d = ses_pkg::S_SHUP;
          end
        end
      end
      ses_pkg::S_SHUP: begin
        if (CntWidth'(idx_q) == pos_q) state_d = ses_pkg::S_PUT;
      end
      ses_pkg::S_PUT: begin
        state_d = ses_pkg::S_IDLE;
      end
      ses_pkg::S_SHDN: begin
        if (CntWidth'(idx_q) >= cnt_q) state_d = ses_pkg::S_IDLE;
      end
      ses_pkg::S_DUMP: begin
        if (dump_last_w) state_d = ses_pkg::S_IDLE;
      end
      default: state_d = ses_pkg::S_IDLE;
    endcase
  end

  // datapath, memory accesses and results
  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    hit_d       = hit_q;
    oldv_d      = oldv_q;
    req_d       = req_q;
    res_vld_d   = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      ses_pkg::S_IDLE: begin
        if (start) begin
          req_d         = in_item_i;
          res_d.out_row = in_item_i.row_index;
          res_d.out_col = in_item_i.col_index;
          res_d.out_value = '0;
          res_d.found   = 1'b0;
          res_d.status  = ses_pkg::STAT_OK;
          res_d.last    = 1'b1;
          if (in_item_i.op == ses_pkg::OP_DUMP) begin
            if (cnt_q == '0) begin
              // empty store: a single result with zero coordinates and value, last set
              res_vld_d     = 1'b1;
              res_d.out_row = '0;
              res_d.out_col = '0;
            end else begin
              mem_re_o = 1'b1;
              idx_d    = '0;
            end
          end else if (!in_range_w) begin
            res_vld_d    = 1'b1;
            res_d.status = ses_pkg::STAT_RANGE;
          end else if (cnt_q == '0) begin
            pos_d = '0;
            hit_d = 1'b0;
          end else begin
            mem_re_o = 1'b1;
            idx_d    = '0;
          end
        end
      end
      ses_pkg::S_SCAN: begin
        // linear lower-bound search, one entry per cycle
        if (rk_lt_w) begin
          if (scan_end_w) begin
            pos_d = cnt_q;
            hit_d = 1'b0;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_q + AddrWidth'(1);
            idx_d       = idx_q + AddrWidth'(1);
          end
        end else begin
          pos_d  = CntWidth'(idx_q);
          hit_d  = mem_rdata_i.key == key_w;
          oldv_d = mem_rdata_i.value;
        end
      end
      ses_pkg::S_ACT: begin
        res_vld_d     = 1'b1;
        res_d.out_row = req_q.row_index;
        res_d.out_col = req_q.col_index;
        res_d.found   = hit_q;
        res_d.status  = ses_pkg::STAT_OK;
        res_d.last    = 1'b1;
        res_d.out_value = '0;
        if (req_q.op == ses_pkg::OP_GET) begin
          res_d.out_value = hit_q ? oldv_q : '0;
        end else if (newv_w == '0) begin
          // delete on zero, shift the tail down
          res_d.status = stat_w;
          if (hit_q) begin
            cnt_d = cnt_q - CntWidth'(1);
            if (shift_dn_w) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AddrWidth'(pos_q + CntWidth'(1));
              idx_d       = AddrWidth'(pos_q + CntWidth'(1));
            end
          end
        end else if (hit_q) begin
          // overwrite in place
          mem_we_o          = 1'b1;
          mem_waddr_o       = AddrWidth'(pos_q);
          mem_wdata_o.key   = key_w;
          mem_wdata_o.value = newv_w;
          res_d.out_value   = newv_w;
          res_d.status      = stat_w;
        end else if (cnt_q == CapCnt) begin
          res_d.status = ses_pkg::STAT_FULL;
        end else begin
          // insert, shifting the tail up when not appending
          cnt_d           = cnt_q + CntWidth'(1);
          res_d.out_value = newv_w;
          if (append_w) begin
            mem_we_o          = 1'b1;
            mem_waddr_o       = AddrWidth'(pos_q);
            mem_wdata_o.key   = key_w;
            mem_wdata_o.value = newv_w;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = AddrWidth'(cnt_q - CntWidth'(1));
            idx_d       = AddrWidth'(cnt_q - CntWidth'(1));
          end
        end
      end
      ses_pkg::S_SHUP: begin
        // move entry idx to idx+1, walking down to the insert point
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q + AddrWidth'(1);
        mem_wdata_o = mem_rdata_i;
        if (CntWidth'(idx_q) != pos_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q - AddrWidth'(1);
          idx_d       = idx_q - AddrWidth'(1);
        end
      end
      ses_pkg::S_PUT: begin
        mem_we_o          = 1'b1;
        mem_waddr_o       = AddrWidth'(pos_q);
        mem_wdata_o.key   = key_w;
        mem_wdata_o.value = newv_w;
      end
      ses_pkg::S_SHDN: begin
        // move entry idx to idx-1, walking up to the old end
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q - AddrWidth'(1);
        mem_wdata_o = mem_rdata_i;
        if (CntWidth'(idx_q) < cnt_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + AddrWidth'(1);
          idx_d       = idx_q + AddrWidth'(1);
        end
      end
      ses_pkg::S_DUMP: begin
        // one entry per cycle in key order
        res_vld_d       = 1'b1;
        res_d.out_row   = mem_rdata_i.key[ses_pkg::KeyWidth-1:ses_pkg::CoordWidth];
        res_d.out_col   = mem_rdata_i.key[ses_pkg::CoordWidth-1:0];
        res_d.out_value = mem_rdata_i.value;
        res_d.found     = 1'b1;
        res_d.status    = ses_pkg::STAT_OK;
        res_d.last      = dump_last_w;
        if (!dump_last_w) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + AddrWidth'(1);
          idx_d       = idx_q + AddrWidth'(1);
        end
      end
      default: begin
        res_vld_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ses_pkg::S_IDLE;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    hit_q  <= hit_d;
    oldv_q <= oldv_d;
    req_q  <= req_d;
    res_q  <= res_d;
  end

  assign busy            = state_q != ses_pkg::S_IDLE;
  assign result_strobe_o = res_vld_q;
  assign result_o        = res_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCnt)
    else $error("entry count above capacity");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re_o && mem_we_o) |-> (mem_raddr_o != mem_waddr_o))
    else $error("read and write hit the same entry in one cycle");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ses_pkg::S_ACT) |-> (pos_q <= cnt_q))
    else $error("search position beyond entry count");

  a_dump_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !result_o.last) |=> result_strobe_o)
    else $error("dump stream broken before last");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ses_pkg::S_SCAN || state_q == ses_pkg::S_DUMP) |-> (cnt_q != '0))
    else $error("memory walk on an empty store");

endmodule

[rtl/sparse_entry_sorted_store.sv]
// Sorted coordinate-list store. Range errors and empty dumps report straight from the idle state;
// get/set/accumulate scan the stored entries, one per cycle through the memory read port, and
// report from the act state; an insert or delete then stays busy while it shifts the tail, and
// an insert that shifts entries then writes the new one in the put state; an append shifts none.
// A dump emits one entry per cycle. One transaction at a time; the receiver cannot stall. Reset
// clears the entry count and sets num_rows/num_cols to 1024; the entry memory is not cleared.
module sparse_entry_sorted_store #(
  parameter int unsigned Capacity = ses_pkg::CapacityDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  ses_pkg::in_item_t            in_item_i,
  output logic                         result_strobe_o,
  output ses_pkg::out_item_t           result_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [ses_pkg::DimWidth-1:0] cfg_wdata_i
);

  localparam int unsigned AddrWidth = $clog2(Capacity);

  logic [ses_pkg::DimWidth-1:0] num_rows_q, num_cols_q;
  logic                 mem_re, mem_we;
  logic [AddrWidth-1:0] mem_raddr, mem_waddr;
  ses_pkg::entry_t      mem_wdata, mem_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= ses_pkg::DimReset;
      num_cols_q <= ses_pkg::DimReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ses_pkg::CfgNumRows: num_rows_q <= cfg_wdata_i;
        ses_pkg::CfgNumCols: num_cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer
  ses_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .in_item_i       (in_item_i),
    .num_rows_i      (num_rows_q),
    .num_cols_i      (num_cols_q),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_rdata_i     (mem_rdata)
  );

  // entry storage
  ses_entry_mem #(
    .Depth (Capacity)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule
